@@ sv/sphere_collide_point_push_top_macros.svh @@
// Assertion macros for the sphere collision push block.
// Included by the files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef SPHERE_COLLIDE_POINT_PUSH_TOP_MACROS_SVH
`define SPHERE_COLLIDE_POINT_PUSH_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SCP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SCP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SCP_ASSERT(lbl, prop, msg)
`define SCP_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ sv/scp_pkg.sv @@
// Shared types and constants for the sphere collision push block.
// No dependencies.
`default_nettype none
package scp_pkg;
    localparam int COORD_W    = 32;
    localparam int FRAC_W     = 16;
    localparam int OFF_SHIFT  = 12;
    localparam int REG_W      = 63;
    localparam int REG_IDX_W  = 3;
    localparam int NUM_REGS   = 8;
    localparam int SQ_W       = 62;
    localparam int LEN_W      = 31;
    localparam int SQRT_STEPS = 31;
    localparam int NUM_W      = 48;
    localparam int QUO_W      = 18;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_FWD_ROW_X,
        REG_FWD_ROW_Y,
        REG_FWD_ROW_Z,
        REG_FWD_OFFSET,
        REG_BACK_ROW_X,
        REG_BACK_ROW_Y,
        REG_BACK_ROW_Z,
        REG_BACK_OFFSET
    } reg_idx_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
    } in_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic signed [COORD_W-1:0] out_z;
        logic                      was_pushed;
    } out_item_t;
endpackage
`default_nettype wire

@@ sv/scp_affine.sv @@
// Two-stage 3x3 affine transform: registered products, then registered sums plus offset.
// Depends on scp_pkg.
`default_nettype none
module scp_affine #(
    parameter int IN_W  = 32,
    parameter int KW    = 21,
    parameter int OUT_W = 39
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  logic [2:0][IN_W-1:0]                  in_vec,
    input  logic [2:0][scp_pkg::REG_W-1:0]        rows,
    input  logic [scp_pkg::REG_W-1:0]             offset,
    output logic                                  out_valid,
    output logic [2:0][OUT_W-1:0]                 out_vec
);
    import scp_pkg::*;

    localparam int P_W = IN_W + KW;

    logic [2:0][2:0][P_W-1:0] prod_reg, prod_next;
    logic                     prod_valid_reg;
    logic [2:0][OUT_W-1:0]    sum_reg, sum_next;
    logic                     sum_valid_reg;

    always_comb
    begin
        logic signed [P_W-1:0] a;
        logic signed [P_W-1:0] b;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                a = P_W'($signed(in_vec[i]));
                b = P_W'($signed(rows[i][j*KW +: KW]));
                prod_next[i][j] = a * b;
            end
        end
    end

    always_comb
    begin
        logic signed [OUT_W-1:0] acc;
        for (int j = 0; j < 3; j++)
        begin
            acc = OUT_W'($signed(offset[j*KW +: KW])) <<< OFF_SHIFT;
            for (int i = 0; i < 3; i++)
            begin
                acc = acc + OUT_W'($signed(prod_reg[i][j][P_W-1:FRAC_W]));
            end
            sum_next[j] = acc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            prod_valid_reg <= in_valid;
            sum_valid_reg  <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            sum_reg  <= sum_next;
        end
    end

    assign out_valid = sum_valid_reg;
    assign out_vec   = sum_reg;
endmodule
`default_nettype wire

@@ sv/scp_sqrt_cell.sv @@
// One cell of the square-root chain: resolves one result bit per cycle while en is high.
// Depends on scp_pkg.
`default_nettype none
module scp_sqrt_cell #(
    parameter int SIDE_W = 1,
    parameter int STEP   = 0
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [scp_pkg::SQ_W-1:0]     x_in,
    input  logic [scp_pkg::SQ_W-1:0]     r_in,
    input  logic [SIDE_W-1:0]            side_in,
    output logic                         out_valid,
    output logic [scp_pkg::SQ_W-1:0]     x_out,
    output logic [scp_pkg::SQ_W-1:0]     r_out,
    output logic [SIDE_W-1:0]            side_out
);
    import scp_pkg::*;

    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * STEP);

    logic [SQ_W-1:0]   x_reg, x_next, r_reg, r_next, trial;
    logic [SIDE_W-1:0] side_reg;
    logic              valid_reg;

    always_comb
    begin
        trial = r_in + BIT;
        if (x_in >= trial)
        begin
            x_next = x_in - trial;
            r_next = (r_in >> 1) + BIT;
        end
        else
        begin
            x_next = x_in;
            r_next = r_in >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            r_reg    <= r_next;
            side_reg <= side_in;
        end
    end

    assign out_valid = valid_reg;
    assign x_out     = x_reg;
    assign r_out     = r_reg;
    assign side_out  = side_reg;
endmodule
`default_nettype wire

@@ sv/scp_div_cell.sv @@
// One cell of the three-lane divider chain: one quotient bit per lane per cycle while en is high.
// Depends on scp_pkg.
`default_nettype none
module scp_div_cell #(
    parameter int SIDE_W = 1,
    parameter int STEP   = 0
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic [scp_pkg::LEN_W-1:0]            len_in,
    input  logic [2:0][scp_pkg::NUM_W-1:0]       rem_in,
    input  logic [2:0][scp_pkg::QUO_W-1:0]       q_in,
    input  logic [SIDE_W-1:0]                    side_in,
    output logic                                 out_valid,
    output logic [scp_pkg::LEN_W-1:0]            len_out,
    output logic [2:0][scp_pkg::NUM_W-1:0]       rem_out,
    output logic [2:0][scp_pkg::QUO_W-1:0]       q_out,
    output logic [SIDE_W-1:0]                    side_out
);
    import scp_pkg::*;

    logic [NUM_W-1:0]            dsr;
    logic [2:0][NUM_W-1:0]       rem_reg, rem_next;
    logic [2:0][QUO_W-1:0]       q_reg, q_next;
    logic [LEN_W-1:0]            len_reg;
    logic [SIDE_W-1:0]           side_reg;
    logic                        valid_reg;

    always_comb
    begin
        dsr = NUM_W'(len_in) << STEP;
        for (int j = 0; j < 3; j++)
        begin
            rem_next[j] = rem_in[j];
            q_next[j]   = q_in[j];
            if (rem_in[j] >= dsr)
            begin
                rem_next[j]     = rem_in[j] - dsr;
                q_next[j][STEP] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            q_reg    <= q_next;
            len_reg  <= len_in;
            side_reg <= side_in;
        end
    end

    assign out_valid = valid_reg;
    assign len_out   = len_reg;
    assign rem_out   = rem_reg;
    assign q_out     = q_reg;
    assign side_out  = side_reg;
endmodule
`default_nettype wire

@@ sv/sphere_collide_point_push_top.sv @@
// Sphere collision vertex push: takes one vertex item per clock while not stalled and
// returns one result item per vertex, in order, through the forward transform, inside
// test, square-root chain, divide setup, divider chain, backward transform and output
// register. Every stage advances together; the only stall is the output register held
// by out_ready low, which also drops in_ready.
// Depends on scp_pkg, scp_affine, scp_sqrt_cell, scp_div_cell and the macro header.
`default_nettype none
`include "sphere_collide_point_push_top_macros.svh"
module sphere_collide_point_push_top #(
    parameter int COEFF_WIDTH = 21
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  scp_pkg::in_item_t                 in_item,
    output logic                              out_valid,
    input  logic                              out_ready,
    output scp_pkg::out_item_t                out_item,
    input  logic                              cfg_we,
    input  logic [scp_pkg::REG_IDX_W-1:0]     cfg_index,
    input  logic [scp_pkg::REG_W-1:0]         cfg_data
);
    import scp_pkg::*;

    localparam int KW     = COEFF_WIDTH;
    localparam int C_W    = COORD_W + KW - 14;
    localparam int Q_W    = C_W + KW - 14;
    localparam int SIDE_W = 1 + 3 * C_W;
    localparam logic signed [C_W-1:0] ONE_C = C_W'(1) << FRAC_W;

    // configuration
    logic [NUM_REGS-1:0][REG_W-1:0] cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[REG_FWD_ROW_X]   <= REG_W'(1) << FRAC_W;
            cfg_reg[REG_FWD_ROW_Y]   <= REG_W'(1) << (FRAC_W + KW);
            cfg_reg[REG_FWD_ROW_Z]   <= REG_W'(1) << (FRAC_W + 2 * KW);
            cfg_reg[REG_FWD_OFFSET]  <= '0;
            cfg_reg[REG_BACK_ROW_X]  <= REG_W'(1) << FRAC_W;
            cfg_reg[REG_BACK_ROW_Y]  <= REG_W'(1) << (FRAC_W + KW);
            cfg_reg[REG_BACK_ROW_Z]  <= REG_W'(1) << (FRAC_W + 2 * KW);
            cfg_reg[REG_BACK_OFFSET] <= '0;
        end
        else if (cfg_we)
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    logic        en;
    logic        out_valid_reg;
    out_item_t   out_item_reg;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // forward transform
    logic                  fwd_valid;
    logic [2:0][C_W-1:0]   fwd_c;

    scp_affine #(.IN_W(COORD_W), .KW(KW), .OUT_W(C_W)) u_fwd (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid && in_ready),
        .in_vec    ({in_item.pos_z, in_item.pos_y, in_item.pos_x}),
        .rows      ({cfg_reg[REG_FWD_ROW_Z], cfg_reg[REG_FWD_ROW_Y], cfg_reg[REG_FWD_ROW_X]}),
        .offset    (cfg_reg[REG_FWD_OFFSET]),
        .out_valid (fwd_valid),
        .out_vec   (fwd_c)
    );

    // inside test and squared length
    logic                sq_valid_reg;
    logic                sq_pushed_reg, sq_pushed_next;
    logic [31:0]         sq_s_reg;
    logic [33:0]         sq_sum;
    logic [2:0][C_W-1:0] sq_c_reg;

    always_comb
    begin
        logic signed [33:0] lo;
        logic [2:0]         in_rng;
        sq_sum = '0;
        for (int j = 0; j < 3; j++)
        begin
            in_rng[j] = ($signed(fwd_c[j]) > -ONE_C) && ($signed(fwd_c[j]) < ONE_C);
            lo        = 34'($signed(fwd_c[j][FRAC_W:0]));
            sq_sum    = sq_sum + 34'(lo * lo);
        end
        sq_pushed_next = (&in_rng) && (sq_sum[33:32] == 2'b00);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            sq_valid_reg <= fwd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_pushed_reg <= sq_pushed_next;
            sq_s_reg      <= sq_sum[31:0];
            sq_c_reg      <= fwd_c;
        end
    end

    // square-root chain
    logic                  sr_valid [SQRT_STEPS+1];
    logic [SQ_W-1:0]       sr_x     [SQRT_STEPS+1];
    logic [SQ_W-1:0]       sr_r     [SQRT_STEPS+1];
    logic [SIDE_W-1:0]     sr_side  [SQRT_STEPS+1];

    assign sr_valid[0] = sq_valid_reg;
    assign sr_x[0]     = {sq_s_reg, 30'b0};
    assign sr_r[0]     = '0;
    assign sr_side[0]  = {sq_pushed_reg, sq_c_reg};

    for (genvar g = 0; g < SQRT_STEPS; g++)
    begin : g_sqrt
        scp_sqrt_cell #(.SIDE_W(SIDE_W), .STEP(g)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (sr_valid[g]),
            .x_in      (sr_x[g]),
            .r_in      (sr_r[g]),
            .side_in   (sr_side[g]),
            .out_valid (sr_valid[g+1]),
            .x_out     (sr_x[g+1]),
            .r_out     (sr_r[g+1]),
            .side_out  (sr_side[g+1])
        );
    end

    // divide setup: numerator = |c| * 2^31 + len / 2
    logic                    pp_valid_reg;
    logic [LEN_W-1:0]        pp_len_reg;
    logic [2:0][NUM_W-1:0]   pp_num_reg, pp_num_next;
    logic [SIDE_W-1:0]       pp_side_reg;
    logic [2:0][C_W-1:0]     sr_c;
    logic [LEN_W-1:0]        sr_len;

    assign sr_c   = sr_side[SQRT_STEPS][3*C_W-1:0];
    assign sr_len = sr_r[SQRT_STEPS][LEN_W-1:0];

    always_comb
    begin
        logic [C_W-1:0] mag;
        for (int j = 0; j < 3; j++)
        begin
            mag = sr_c[j][C_W-1] ? -sr_c[j] : sr_c[j];
            pp_num_next[j] = NUM_W'({mag[FRAC_W-1:0], 31'b0}) + NUM_W'(sr_len >> 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pp_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            pp_valid_reg <= sr_valid[SQRT_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_len_reg  <= sr_len;
            pp_num_reg  <= pp_num_next;
            pp_side_reg <= sr_side[SQRT_STEPS];
        end
    end

    // divider chain
    logic                    dv_valid [QUO_W+1];
    logic [LEN_W-1:0]        dv_len   [QUO_W+1];
    logic [2:0][NUM_W-1:0]   dv_rem   [QUO_W+1];
    logic [2:0][QUO_W-1:0]   dv_q     [QUO_W+1];
    logic [SIDE_W-1:0]       dv_side  [QUO_W+1];

    assign dv_valid[0] = pp_valid_reg;
    assign dv_len[0]   = pp_len_reg;
    assign dv_rem[0]   = pp_num_reg;
    assign dv_q[0]     = '0;
    assign dv_side[0]  = pp_side_reg;

    for (genvar g = 0; g < QUO_W; g++)
    begin : g_div
        scp_div_cell #(.SIDE_W(SIDE_W), .STEP(QUO_W - 1 - g)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (dv_valid[g]),
            .len_in    (dv_len[g]),
            .rem_in    (dv_rem[g]),
            .q_in      (dv_q[g]),
            .side_in   (dv_side[g]),
            .out_valid (dv_valid[g+1]),
            .len_out   (dv_len[g+1]),
            .rem_out   (dv_rem[g+1]),
            .q_out     (dv_q[g+1]),
            .side_out  (dv_side[g+1])
        );
    end

    // pick pushed or original collider point
    logic                  dv_pushed, push_div;
    logic [2:0][C_W-1:0]   dv_c, bk_in;

    assign dv_pushed = dv_side[QUO_W][SIDE_W-1];
    assign dv_c      = dv_side[QUO_W][3*C_W-1:0];
    assign push_div  = dv_pushed && (dv_len[QUO_W] != '0);

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            if (push_div)
            begin
                bk_in[j] = dv_c[j][C_W-1] ? -C_W'(dv_q[QUO_W][j]) : C_W'(dv_q[QUO_W][j]);
            end
            else
            begin
                bk_in[j] = dv_c[j];
            end
        end
    end

    // backward transform
    logic                 bk_valid;
    logic [2:0][Q_W-1:0]  bk_q;
    logic                 pd1_reg, pd2_reg;

    scp_affine #(.IN_W(C_W), .KW(KW), .OUT_W(Q_W)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (dv_valid[QUO_W]),
        .in_vec    (bk_in),
        .rows      ({cfg_reg[REG_BACK_ROW_Z], cfg_reg[REG_BACK_ROW_Y],
                     cfg_reg[REG_BACK_ROW_X]}),
        .offset    (cfg_reg[REG_BACK_OFFSET]),
        .out_valid (bk_valid),
        .out_vec   (bk_q)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pd1_reg <= dv_pushed;
            pd2_reg <= pd1_reg;
        end
    end

    // saturate and output register
    logic [2:0][COORD_W-1:0] sat_q;

    always_comb
    begin
        logic [Q_W-COORD_W:0] top;
        for (int j = 0; j < 3; j++)
        begin
            top = bk_q[j][Q_W-1:COORD_W-1];
            if ((&top) || !(|top))
            begin
                sat_q[j] = bk_q[j][COORD_W-1:0];
            end
            else if (bk_q[j][Q_W-1])
            begin
                sat_q[j] = {1'b1, {(COORD_W-1){1'b0}}};
            end
            else
            begin
                sat_q[j] = {1'b0, {(COORD_W-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= bk_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_item_reg.out_x      <= sat_q[0];
            out_item_reg.out_y      <= sat_q[1];
            out_item_reg.out_z      <= sat_q[2];
            out_item_reg.was_pushed <= pd2_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    `SCP_ASSERT(a_len_fits, (sr_valid[SQRT_STEPS] && sr_side[SQRT_STEPS][SIDE_W-1]) |-> (sr_r[SQRT_STEPS][SQ_W-1:LEN_W] == '0), "root wider than length field")
    `SCP_ASSERT(a_quo_fits, (dv_valid[QUO_W] && push_div) |-> (!dv_q[QUO_W][0][QUO_W-1] && !dv_q[QUO_W][1][QUO_W-1] && !dv_q[QUO_W][2][QUO_W-1]), "pushed component out of range")
    `SCP_ASSERT(a_stall_freezes, !en |=> ($stable(sq_valid_reg) && $stable(sq_s_reg)), "pipeline moved while stalled")
endmodule
`default_nettype wire
